// ===== rtl/core/bfifo_pkg.sv =====
// bfifo_pkg: shared types and constants of the byte ring fifo
// holds the command codes, item structs and store geometry; no dependencies
package bfifo_pkg;

    // store geometry
    localparam int DEPTH_LOG2 = 10;
    localparam int DEPTH      = 1 << DEPTH_LOG2;
    localparam int ADDR_W     = DEPTH_LOG2;
    localparam int PTR_W      = DEPTH_LOG2 + 1;
    localparam int LG_W       = $clog2(DEPTH_LOG2 + 1);

    // fixed field widths
    localparam int DATA_W  = 8;
    localparam int COUNT_W = 11;
    localparam int CFG_W   = 4;
    localparam int CALC_W  = (PTR_W > COUNT_W) ? PTR_W : COUNT_W;

    // capacity register after reset
    localparam logic [CFG_W-1:0] CAP_LOG2_RESET = CFG_W'(10);

    // largest fill level the store can hold
    localparam logic [COUNT_W-1:0] FILL_MAX = COUNT_W'(DEPTH);

    // command codes
    typedef enum logic [1:0] {
        CMD_PUT     = 2'd0,
        CMD_GET     = 2'd1,
        CMD_SKIP    = 2'd2,
        CMD_RESERVE = 2'd3
    } cmd_t;

    // input item
    typedef struct packed {
        cmd_t                command;
        logic [DATA_W-1:0]   data_in;
        logic [COUNT_W-1:0]  count;
    } req_t;

    // result item
    typedef struct packed {
        logic                ok;
        logic [DATA_W-1:0]   data_out;
        logic [COUNT_W-1:0]  moved;
        logic [COUNT_W-1:0]  fill_level;
    } rsp_t;

    // store access from the controller
    typedef struct packed {
        logic                we;
        logic [ADDR_W-1:0]   addr;
        logic [DATA_W-1:0]   wdata;
    } ram_req_t;

endpackage

// ===== rtl/core/bfifo_ram.sv =====
// bfifo_ram: generic single-port synchronous ram with registered read
// stand-alone, no package dependencies
module bfifo_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/core/bfifo_ctrl.sv =====
// bfifo_ctrl: pointer registers, clamping and result registers of the byte fifo
// uses bfifo_pkg; drives the store through a ram_req_t and takes its read data
module bfifo_ctrl (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  bfifo_pkg::req_t               request,
    input  logic                          cfg_we,
    input  logic [bfifo_pkg::CFG_W-1:0]   cfg_data,
    input  logic [bfifo_pkg::DATA_W-1:0]  ram_rdata,
    output bfifo_pkg::ram_req_t           ram_req,
    output logic                          done,
    output bfifo_pkg::rsp_t               result
);

    logic [bfifo_pkg::CFG_W-1:0]   cap_log2_reg;
    logic [bfifo_pkg::PTR_W-1:0]   wp_reg, wp_next;
    logic [bfifo_pkg::PTR_W-1:0]   rp_reg, rp_next;
    logic                          done_reg;
    logic                          get_reg, get_next;
    logic                          ok_reg, ok_next;
    logic [bfifo_pkg::COUNT_W-1:0] moved_reg, moved_next;
    logic [bfifo_pkg::COUNT_W-1:0] fill_reg, fill_next;

    logic [bfifo_pkg::LG_W-1:0]    cap_lg;
    logic [bfifo_pkg::PTR_W-1:0]   cap;
    logic [bfifo_pkg::ADDR_W-1:0]  mask;
    logic [bfifo_pkg::PTR_W-1:0]   fill;
    logic [bfifo_pkg::PTR_W-1:0]   room;
    logic [bfifo_pkg::CALC_W-1:0]  cnt_ext;
    logic [bfifo_pkg::CALC_W-1:0]  clamp;
    logic [bfifo_pkg::PTR_W-1:0]   moved_ptr;
    logic [bfifo_pkg::PTR_W-1:0]   fill_after;

    // capacity in use, saturated at the store depth
    always_comb
    begin
        if (32'(cap_log2_reg) > bfifo_pkg::DEPTH_LOG2)
        begin
            cap_lg = bfifo_pkg::LG_W'(bfifo_pkg::DEPTH_LOG2);
        end
        else
        begin
            cap_lg = bfifo_pkg::LG_W'(cap_log2_reg);
        end
    end

    assign cap  = bfifo_pkg::PTR_W'(1) << cap_lg;
    assign mask = bfifo_pkg::ADDR_W'(cap - bfifo_pkg::PTR_W'(1));
    assign fill = wp_reg - rp_reg;
    assign room = (cap > fill) ? (cap - fill) : '0;

    // clamp of the count against fill level or free space
    always_comb
    begin
        cnt_ext = bfifo_pkg::CALC_W'(request.count);
        if (request.command == bfifo_pkg::CMD_SKIP)
        begin
            clamp = (cnt_ext > bfifo_pkg::CALC_W'(fill)) ? bfifo_pkg::CALC_W'(fill) : cnt_ext;
        end
        else
        begin
            clamp = (cnt_ext > bfifo_pkg::CALC_W'(room)) ? bfifo_pkg::CALC_W'(room) : cnt_ext;
        end
        moved_ptr = bfifo_pkg::PTR_W'(clamp);
    end

    // command decode: pointer update, store access and result fields
    always_comb
    begin
        wp_next       = wp_reg;
        rp_next       = rp_reg;
        ok_next       = 1'b0;
        get_next      = 1'b0;
        moved_next    = '0;
        ram_req.we    = 1'b0;
        ram_req.addr  = '0;
        ram_req.wdata = request.data_in;
        case (request.command)
            bfifo_pkg::CMD_PUT:
            begin
                ram_req.addr = wp_reg[bfifo_pkg::ADDR_W-1:0] & mask;
                if (room != '0)
                begin
                    ram_req.we = start;
                    wp_next    = wp_reg + bfifo_pkg::PTR_W'(1);
                    ok_next    = 1'b1;
                    moved_next = bfifo_pkg::COUNT_W'(1);
                end
            end
            bfifo_pkg::CMD_GET:
            begin
                ram_req.addr = rp_reg[bfifo_pkg::ADDR_W-1:0] & mask;
                if (fill != '0)
                begin
                    rp_next    = rp_reg + bfifo_pkg::PTR_W'(1);
                    ok_next    = 1'b1;
                    get_next   = 1'b1;
                    moved_next = bfifo_pkg::COUNT_W'(1);
                end
            end
            bfifo_pkg::CMD_SKIP:
            begin
                rp_next    = rp_reg + moved_ptr;
                ok_next    = (clamp != '0);
                moved_next = bfifo_pkg::COUNT_W'(clamp);
            end
            default:
            begin
                wp_next    = wp_reg + moved_ptr;
                ok_next    = (clamp != '0);
                moved_next = bfifo_pkg::COUNT_W'(clamp);
            end
        endcase
        fill_after = wp_next - rp_next;
        fill_next  = bfifo_pkg::COUNT_W'(fill_after);
    end

    // control state: capacity, pointers, result strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_log2_reg <= bfifo_pkg::CAP_LOG2_RESET;
            wp_reg       <= '0;
            rp_reg       <= '0;
            done_reg     <= 1'b0;
            get_reg      <= 1'b0;
        end
        else
        begin
            done_reg <= start;
            if (cfg_we)
            begin
                cap_log2_reg <= cfg_data;
                wp_reg       <= '0;
                rp_reg       <= '0;
                get_reg      <= 1'b0;
            end
            else if (start)
            begin
                wp_reg  <= wp_next;
                rp_reg  <= rp_next;
                get_reg <= get_next;
            end
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            ok_reg    <= ok_next;
            moved_reg <= moved_next;
            fill_reg  <= fill_next;
        end
    end

    assign done              = done_reg;
    assign result.ok         = ok_reg;
    assign result.data_out   = get_reg ? ram_rdata : '0;
    assign result.moved      = moved_reg;
    assign result.fill_level = fill_reg;

endmodule

// ===== rtl/core/byte_ring_fifo.sv =====
// byte_ring_fifo: result strobed on done the cycle after start
// throughput one item per cycle; busy stays low, pointers bypass into the next item
// the store ram read is registered, so GET data arrives together with the other result fields
// reset: pointers cleared, capacity log2 set to 10, store content undefined
// results cannot be stalled by the receiver
// top level: uses bfifo_pkg, bfifo_ctrl and bfifo_ram
module byte_ring_fifo (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  bfifo_pkg::req_t                 request,
    output logic                            done,
    output bfifo_pkg::rsp_t                 result,
    input  logic                            cfg_we,
    input  logic [bfifo_pkg::CFG_W-1:0]     cfg_data
);

    bfifo_pkg::ram_req_t            ram_req;
    logic [bfifo_pkg::DATA_W-1:0]   ram_rdata;

    // one item per cycle, never stalls
    assign busy = 1'b0;

    // pointer and result control
    bfifo_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .request   (request),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data),
        .ram_rdata (ram_rdata),
        .ram_req   (ram_req),
        .done      (done),
        .result    (result)
    );

    // byte store
    bfifo_ram #(
        .WIDTH (bfifo_pkg::DATA_W),
        .DEPTH (bfifo_pkg::DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_req.we),
        .addr  (ram_req.addr),
        .wdata (ram_req.wdata),
        .rdata (ram_rdata)
    );

    // every accepted item gives one result in the next cycle
    a_done_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> done)
        else $error("accepted item gave no result");

    // no result without an item
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        !start |=> !done)
        else $error("result without an accepted item");

    // ok tracks a nonzero move count
    a_ok_moved: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (result.ok == (result.moved != '0)))
        else $error("ok does not match moved count");

    // fill level never exceeds the store depth
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (result.fill_level <= bfifo_pkg::FILL_MAX))
        else $error("fill level beyond store depth");

endmodule
